### rtl/vac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vac_pkg
// Shared constants, register codes and types of the voxel box collision query.
// ----------------------------------------------------------------------------
package vac_pkg;

  localparam int CHUNK_W_DEF   = 16;
  localparam int CHUNK_H_DEF   = 16;
  localparam int FRAC_BITS_DEF = 8;

  localparam int POS_W    = 24;
  localparam int COORD_W  = 12;
  localparam int HEIGHT_W = 10;
  localparam int HALF_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 3;
  // chunk sizes up to 256 voxels along an axis
  localparam int SIZE_W   = 9;
  // axis arithmetic width: covers position, box extent and chunk base
  localparam int AX_W     = 28;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 8;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd461;
  localparam logic [HALF_W-1:0]   HALF_RST   = 8'd102;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_VALID   = 3'd0,
    REG_CHUNK_X       = 3'd1,
    REG_CHUNK_Y       = 3'd2,
    REG_CHUNK_Z       = 3'd3,
    REG_PLAYER_HEIGHT = 3'd4,
    REG_HALF_WIDTH    = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              present;
    logic              empty;
    logic [SIZE_W-1:0] first;
    logic [SIZE_W-1:0] last;
  } axis_res_t;

endpackage

### rtl/voxel_aabb_collision_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_aabb_collision_query
// Body box versus one resident voxel chunk: voxel writes and collision queries.
// ----------------------------------------------------------------------------
// write transaction: written to the occupancy memory on acceptance, no result
// query: setup through the one shared axis unit, one axis at a time, then one
//   occupancy memory read per cycle over the voxels of the overlap range; a miss
//   or an empty range skips the reads and goes straight to the result
// next input accepted in the cycle after the result is loaded into the output
// reset: clearing pass over all CHUNK_W*CHUNK_W*CHUNK_H voxels (4096 by default)
// ----------------------------------------------------------------------------
module voxel_aabb_collision_query #(
  parameter int CHUNK_W   = vac_pkg::CHUNK_W_DEF,
  parameter int CHUNK_H   = vac_pkg::CHUNK_H_DEF,
  parameter int FRAC_BITS = vac_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg
  input  logic                              cfg_we,
  input  logic [vac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vac_pkg::CFG_W-1:0]         cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, pos_z, voxel_index, voxel_solid
  input  logic [vac_pkg::IN_DATA_W-1:0]     s_tdata,
  // cmd
  input  logic                              s_tuser,
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hit, chunk_present
  output logic [vac_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import vac_pkg::*;

  localparam int VOX_COUNT = CHUNK_W * CHUNK_W * CHUNK_H;
  localparam int ADDR_W    = $clog2(VOX_COUNT);
  localparam int XW        = $clog2(CHUNK_W);
  localparam int YW        = $clog2(CHUNK_H);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_AXIS  = 6'b000100,
    S_WALK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  state_t state, state_next;
  axis_t  axis;

  // config
  logic                       chunk_valid;
  logic signed [COORD_W-1:0]  chunk_x;
  logic signed [COORD_W-1:0]  chunk_y;
  logic signed [COORD_W-1:0]  chunk_z;
  logic [HEIGHT_W-1:0]        player_height;
  logic [HALF_W-1:0]          half_width;

  // input fields
  logic signed [POS_W-1:0]    in_pos_x;
  logic signed [POS_W-1:0]    in_pos_y;
  logic signed [POS_W-1:0]    in_pos_z;
  logic [INDEX_W-1:0]         in_index;
  logic                       in_solid;
  logic                       accept;

  // query state
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic signed [POS_W-1:0]    pos_z;
  logic                       pres_acc;
  logic                       empty_acc;
  logic                       hit_acc;
  logic [XW-1:0]              x_first, x_last, xcnt;
  logic [YW-1:0]              y_first, y_last, ycnt;
  logic [XW-1:0]              z_first, z_last, zcnt;
  logic                       walk_last;

  // shared axis unit
  logic signed [POS_W-1:0]    u_pos;
  logic [HEIGHT_W-1:0]        u_ext_lo;
  logic [HEIGHT_W-1:0]        u_ext_hi;
  logic signed [COORD_W-1:0]  u_coord;
  logic [SIZE_W-1:0]          u_size;
  axis_res_t                  u_res;
  logic                       pres_final;
  logic                       empty_final;

  // occupancy store
  logic                       mem [VOX_COUNT];
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic                       mem_wdata;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       rd_data;
  logic                       rd_pend;
  logic [ADDR_W-1:0]          clr_cnt;
  logic                       idx_ok;

  // output register
  logic                       out_hit;
  logic                       out_present;

  assign in_pos_x = s_tdata[23:0];
  assign in_pos_y = s_tdata[47:24];
  assign in_pos_z = s_tdata[71:48];
  assign in_index = s_tdata[83:72];
  assign in_solid = s_tdata[84];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_present, out_hit};

  assign idx_ok = (32'(in_index) < VOX_COUNT);

  always_comb begin
    unique case (axis)
      AX_Y: begin
        u_pos    = pos_y;
        u_ext_lo = player_height;
        u_ext_hi = '0;
        u_coord  = chunk_y;
        u_size   = SIZE_W'(CHUNK_H);
      end
      AX_Z: begin
        u_pos    = pos_z;
        u_ext_lo = HEIGHT_W'(half_width);
        u_ext_hi = HEIGHT_W'(half_width);
        u_coord  = chunk_z;
        u_size   = SIZE_W'(CHUNK_W);
      end
      default: begin
        u_pos    = pos_x;
        u_ext_lo = HEIGHT_W'(half_width);
        u_ext_hi = HEIGHT_W'(half_width);
        u_coord  = chunk_x;
        u_size   = SIZE_W'(CHUNK_W);
      end
    endcase
  end

  vac_axis_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_axis (
    .pos    (u_pos),
    .ext_lo (u_ext_lo),
    .ext_hi (u_ext_hi),
    .coord  (u_coord),
    .size   (u_size),
    .res    (u_res)
  );

  assign pres_final  = pres_acc && u_res.present;
  assign empty_final = empty_acc || u_res.empty;
  assign walk_last   = (xcnt == x_last) && (ycnt == y_last) && (zcnt == z_last);

  assign rd_addr = ADDR_W'(32'(ycnt) * (CHUNK_W * CHUNK_W) + 32'(zcnt) * CHUNK_W + 32'(xcnt));

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = 1'b0;
    end else begin
      mem_we    = accept && (s_tuser == CMD_WRITE) && idx_ok;
      mem_waddr = ADDR_W'(in_index);
      mem_wdata = in_solid;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == ADDR_W'(VOX_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && (s_tuser == CMD_QUERY)) state_next = S_AXIS;
      end
      S_AXIS: begin
        if (axis == AX_Z) begin
          if (pres_final && !empty_final) state_next = S_WALK;
          else state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      axis          <= AX_X;
      rd_pend       <= 1'b0;
      m_tvalid      <= 1'b0;
      chunk_valid   <= 1'b0;
      chunk_x       <= '0;
      chunk_y       <= '0;
      chunk_z       <= '0;
      player_height <= HEIGHT_RST;
      half_width    <= HALF_RST;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_WALK);

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CHUNK_VALID:   chunk_valid   <= cfg_data[0];
          REG_CHUNK_X:       chunk_x       <= cfg_data;
          REG_CHUNK_Y:       chunk_y       <= cfg_data;
          REG_CHUNK_Z:       chunk_z       <= cfg_data;
          REG_PLAYER_HEIGHT: player_height <= cfg_data[HEIGHT_W-1:0];
          REG_HALF_WIDTH:    half_width    <= cfg_data[HALF_W-1:0];
          default: ;
        endcase
      end

      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end

      if (state == S_IDLE) begin
        axis <= AX_X;
      end else if (state == S_AXIS) begin
        unique case (axis)
          AX_X:    axis <= AX_Y;
          AX_Y:    axis <= AX_Z;
          default: axis <= AX_X;
        endcase
      end

      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x     <= in_pos_x;
      pos_y     <= in_pos_y;
      pos_z     <= in_pos_z;
      pres_acc  <= chunk_valid;
      empty_acc <= 1'b0;
      hit_acc   <= 1'b0;
    end

    if (state == S_AXIS) begin
      pres_acc  <= pres_final;
      empty_acc <= empty_final;
      unique case (axis)
        AX_X: begin
          x_first <= XW'(u_res.first);
          x_last  <= XW'(u_res.last);
        end
        AX_Y: begin
          y_first <= YW'(u_res.first);
          y_last  <= YW'(u_res.last);
        end
        default: begin
          z_first <= XW'(u_res.first);
          z_last  <= XW'(u_res.last);
          xcnt    <= x_first;
          ycnt    <= y_first;
          zcnt    <= XW'(u_res.first);
        end
      endcase
    end

    if (state == S_WALK) begin
      if (zcnt != z_last) begin
        zcnt <= zcnt + XW'(1);
      end else begin
        zcnt <= z_first;
        if (ycnt != y_last) begin
          ycnt <= ycnt + YW'(1);
        end else begin
          ycnt <= y_first;
          xcnt <= xcnt + XW'(1);
        end
      end
    end

    if (rd_pend && rd_data) begin
      hit_acc <= 1'b1;
    end

    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      out_hit     <= hit_acc;
      out_present <= pres_acc;
    end
  end

endmodule

### rtl/vac_axis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vac_axis_unit
// Shared per-axis unit: chunk membership and clamped overlapping voxel range.
// ----------------------------------------------------------------------------
module vac_axis_unit #(
  parameter int FRAC_BITS = vac_pkg::FRAC_BITS_DEF
) (
  input  logic signed [vac_pkg::POS_W-1:0]    pos,
  input  logic        [vac_pkg::HEIGHT_W-1:0] ext_lo,
  input  logic        [vac_pkg::HEIGHT_W-1:0] ext_hi,
  input  logic signed [vac_pkg::COORD_W-1:0]  coord,
  input  logic        [vac_pkg::SIZE_W-1:0]   size,
  output vac_pkg::axis_res_t                  res
);
  import vac_pkg::*;

  localparam logic signed [AX_W-1:0] ZERO    = '0;
  localparam logic signed [AX_W-1:0] ONE_LSB = AX_W'(1);

  logic signed [AX_W-1:0] p_w;
  logic signed [AX_W-1:0] elo_w;
  logic signed [AX_W-1:0] ehi_w;
  logic signed [AX_W-1:0] size_w;
  logic signed [AX_W-1:0] coord_w;
  logic signed [AX_W-1:0] lo;
  logic signed [AX_W-1:0] hi_m1;
  logic signed [AX_W-1:0] pos_vox;
  logic signed [AX_W-1:0] base;
  logic signed [AX_W-1:0] top;
  logic signed [AX_W-1:0] rf;
  logic signed [AX_W-1:0] rl;
  logic signed [AX_W-1:0] nm1;

  assign p_w     = AX_W'(pos);
  assign coord_w = AX_W'(coord);
  assign elo_w   = $signed({{(AX_W-HEIGHT_W){1'b0}}, ext_lo});
  assign ehi_w   = $signed({{(AX_W-HEIGHT_W){1'b0}}, ext_hi});
  assign size_w  = $signed({{(AX_W-SIZE_W){1'b0}}, size});

  assign lo      = p_w - elo_w;
  assign hi_m1   = p_w + ehi_w - ONE_LSB;
  assign pos_vox = p_w >>> FRAC_BITS;
  assign base    = coord_w * size_w;
  assign top     = base + size_w;
  assign nm1     = size_w - ONE_LSB;

  // strict overlap range: floor(lo) .. floor(hi - lsb), chunk relative
  assign rf = (lo >>> FRAC_BITS) - base;
  assign rl = (hi_m1 >>> FRAC_BITS) - base;

  assign res.present = (pos_vox >= base) && (pos_vox < top);
  assign res.empty   = (rf > rl) || (rl < ZERO) || (rf > nm1);
  assign res.first   = (rf < ZERO) ? '0 : rf[SIZE_W-1:0];
  assign res.last    = (rl > nm1) ? nm1[SIZE_W-1:0] : rl[SIZE_W-1:0];

endmodule
